FILE: hw/rtl/pcc_pkg.sv
// shared types and constants for the path conflict counter
// no dependencies; every other file imports this package
package pcc_pkg;

    localparam int PCC_MAX_AGENTS = 8;
    localparam int PCC_COORD_BITS = 10;

    // fixed widths of the channel fields
    localparam int AGENT_W = 3;
    localparam int XY_W    = 10;
    localparam int STEP_W  = 16;
    localparam int TOT_W   = 32;

    typedef enum logic [1:0] {
        K_TALLY  = 2'd0,
        K_VERTEX = 2'd1,
        K_SAME   = 2'd2,
        K_SWAP   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREV,
        S_CMP,
        S_EMIT,
        S_TALLY
    } state_t;

    // pending record flags of one compared pair, in emission order
    localparam int P_VERTEX = 0;
    localparam int P_SAME   = 1;
    localparam int P_SWAP_A = 2;
    localparam int P_SWAP_B = 3;

endpackage

FILE: hw/rtl/pcc_if.sv
// valid/ready channel interfaces of the path conflict counter
// depends on pcc_pkg for the field widths
interface pcc_path_if import pcc_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [AGENT_W-1:0] agent;
    logic [XY_W-1:0]    pos_x;
    logic [XY_W-1:0]    pos_y;
    logic               present;
    logic               step_end;
    logic               restart;

    modport source (
        output valid, agent, pos_x, pos_y, present, step_end, restart,
        input  ready
    );
    modport sink (
        input  valid, agent, pos_x, pos_y, present, step_end, restart,
        output ready
    );
endinterface

interface pcc_report_if import pcc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic [XY_W-1:0]   at_x;
    logic [XY_W-1:0]   at_y;
    logic [STEP_W-1:0] at_step;
    logic [TOT_W-1:0]  vertex_total;
    logic [TOT_W-1:0]  same_total;
    logic [TOT_W-1:0]  swap_total;
    logic              final_res;

    modport source (
        output valid, kind, at_x, at_y, at_step, vertex_total, same_total,
               swap_total, final_res,
        input  ready
    );
    modport sink (
        input  valid, kind, at_x, at_y, at_step, vertex_total, same_total,
               swap_total, final_res,
        output ready
    );
endinterface

FILE: hw/rtl/pcc_cell_mem.sv
// two-bank cell store: current and previous step cells per agent
// one write port, two registered read ports; uses pcc_pkg
module pcc_cell_mem import pcc_pkg::*; #(
    parameter int IDX_W  = 3,
    parameter int CELL_W = 20
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [IDX_W:0]    wr_addr,
    input  logic [CELL_W-1:0] wr_data,
    input  logic [IDX_W:0]    rd_a_addr,
    input  logic [IDX_W:0]    rd_b_addr,
    output logic [CELL_W-1:0] rd_a_data,
    output logic [CELL_W-1:0] rd_b_data
);

    localparam int DEPTH = 2 << IDX_W;

    logic [CELL_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_a_data <= mem[rd_a_addr];
        rd_b_data <= mem[rd_b_addr];
    end

endmodule

FILE: hw/rtl/path_conflict_counter.sv
// path conflict counter: pairwise vertex, edge and swap conflicts of agent paths
// top level; uses pcc_pkg, pcc_if and pcc_cell_mem
//
// path channel: one request per agent position of a timestep, agents in rising
// order, step_end on the last agent, restart to clear totals and timestep.
// report channel: zero or more conflict records (vertex, same-direction edge,
// two per swap) followed by one tally record with final_res set.
// one request is handled at a time; path.ready is high only while idle.
// each request passes through an accept step, a fetch of the agent's previous
// cell (present agents above index 0), a compare step per lower agent through
// the shared cell comparator, an emit step per record and a tally step.
// records leave through an output register; a stalled report channel holds
// the register and the sequencer waits for it to empty before each record.
// reset clears presence bits, timestep and totals; stored cells stay
// undefined and are never used before being written.
module path_conflict_counter import pcc_pkg::*; #(
    parameter int MAX_AGENTS = PCC_MAX_AGENTS,
    parameter int COORD_BITS = PCC_COORD_BITS
) (
    input  logic       clk,
    input  logic       rst_n,
    pcc_path_if.sink   path,
    pcc_report_if.source report
);

    localparam int AW = (MAX_AGENTS > 1) ? $clog2(MAX_AGENTS) : 1;
    localparam int CW = 2 * COORD_BITS;

    state_t state_reg, state_next;

    logic [AW-1:0]         me_reg, me_next;
    logic [AW-1:0]         i_reg, i_next;
    logic [CW-1:0]         cell_reg, cell_next;
    logic [CW-1:0]         prev_me_reg, prev_me_next;
    logic                  step_end_reg, step_end_next;
    logic                  edge_ok_reg, edge_ok_next;
    logic [3:0]            pend_reg, pend_next;
    logic                  bank_reg, bank_next;
    logic [MAX_AGENTS-1:0] cur_present_reg, cur_present_next;
    logic [MAX_AGENTS-1:0] prev_present_reg, prev_present_next;
    logic [STEP_W-1:0]     timestep_reg, timestep_next;
    logic [TOT_W-1:0]      vertex_reg, vertex_next;
    logic [TOT_W-1:0]      same_reg, same_next;
    logic [TOT_W-1:0]      swap_reg, swap_next;

    logic                  out_valid_reg, out_valid_next;
    kind_t                 out_kind_reg, out_kind_next;
    logic [CW-1:0]         out_cell_reg, out_cell_next;
    logic [STEP_W-1:0]     out_step_reg, out_step_next;
    logic [TOT_W-1:0]      out_vertex_reg, out_vertex_next;
    logic [TOT_W-1:0]      out_same_reg, out_same_next;
    logic [TOT_W-1:0]      out_swap_reg, out_swap_next;
    logic                  out_final_reg, out_final_next;

    logic          accept;
    logic          slot_free;
    logic          agent_ok;
    logic [AW-1:0] me_in;
    logic [CW-1:0] cell_in;
    logic          last_i;
    logic          hit_v, hit_s, hit_w;
    logic [3:0]    hits;
    logic [3:0]    sel;
    logic [3:0]    remain;

    logic          wr_en;
    logic [AW:0]   wr_addr;
    logic [AW:0]   rd_a_addr, rd_b_addr;
    logic [CW-1:0] rd_a_data, rd_b_data;

    assign path.ready = (state_reg == S_IDLE);
    assign accept     = path.valid && path.ready;
    assign slot_free  = !out_valid_reg || report.ready;
    assign agent_ok   = int'(path.agent) < MAX_AGENTS;
    assign me_in      = AW'(path.agent);
    assign cell_in    = {COORD_BITS'(path.pos_y), COORD_BITS'(path.pos_x)};
    assign last_i     = (i_reg == AW'(me_reg - 1'b1));

    // shared comparator: stored lower agent against the arriving one
    always_comb
    begin
        logic edges;
        edges = edge_ok_reg && prev_present_reg[i_reg];
        hit_v = cur_present_reg[i_reg] && (rd_a_data == cell_reg);
        hit_s = hit_v && edges && (rd_b_data == prev_me_reg);
        hit_w = cur_present_reg[i_reg] && edges && (rd_b_data == cell_reg)
                && (prev_me_reg == rd_a_data);
        hits  = {hit_w, hit_w, hit_s, hit_v};
    end

    assign sel    = pend_reg & (~pend_reg + 4'd1);
    assign remain = pend_reg & ~sel;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (path.valid)
                begin
                    if (agent_ok && path.present && (me_in != '0))
                        state_next = S_PREV;
                    else
                        state_next = S_TALLY;
                end
            end
            S_PREV:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (hits != 4'd0)
                    state_next = S_EMIT;
                else if (last_i)
                    state_next = S_TALLY;
            end
            S_EMIT:
            begin
                if (slot_free && (remain == 4'd0))
                    state_next = last_i ? S_TALLY : S_CMP;
            end
            S_TALLY:
            begin
                if (slot_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and output register control
    always_comb
    begin
        me_next           = me_reg;
        i_next            = i_reg;
        cell_next         = cell_reg;
        prev_me_next      = prev_me_reg;
        step_end_next     = step_end_reg;
        edge_ok_next      = edge_ok_reg;
        pend_next         = pend_reg;
        bank_next         = bank_reg;
        cur_present_next  = cur_present_reg;
        prev_present_next = prev_present_reg;
        timestep_next     = timestep_reg;
        vertex_next       = vertex_reg;
        same_next         = same_reg;
        swap_next         = swap_reg;

        out_valid_next    = out_valid_reg && !report.ready;
        out_kind_next     = out_kind_reg;
        out_cell_next     = out_cell_reg;
        out_step_next     = out_step_reg;
        out_vertex_next   = out_vertex_reg;
        out_same_next     = out_same_reg;
        out_swap_next     = out_swap_reg;
        out_final_next    = out_final_reg;

        wr_en   = 1'b0;
        wr_addr = {bank_reg, me_in};

        case (state_reg)
            S_IDLE:
            begin
                i_next = '0;
                if (accept)
                begin
                    me_next       = me_in;
                    cell_next     = cell_in;
                    step_end_next = path.step_end;
                    if (path.restart)
                    begin
                        vertex_next       = '0;
                        same_next         = '0;
                        swap_next         = '0;
                        timestep_next     = '0;
                        cur_present_next  = '0;
                        prev_present_next = '0;
                    end
                    if (agent_ok)
                    begin
                        cur_present_next[me_in] = path.present;
                        wr_en = path.present;
                    end
                end
            end
            S_PREV:
            begin
                prev_me_next = rd_a_data;
                edge_ok_next = (timestep_reg != '0) && prev_present_reg[me_reg];
            end
            S_CMP:
            begin
                pend_next = hits;
                if ((hits == 4'd0) && !last_i)
                    i_next = i_reg + 1'b1;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    pend_next = remain;
                    out_valid_next = 1'b1;
                    out_final_next = 1'b0;
                    out_step_next  = timestep_reg;
                    out_cell_next  = sel[P_SWAP_B] ? cell_reg : rd_a_data;
                    if (sel[P_VERTEX] && (vertex_reg != '1))
                        vertex_next = vertex_reg + 1'b1;
                    if (sel[P_SAME] && (same_reg != '1))
                        same_next = same_reg + 1'b1;
                    if (sel[P_SWAP_A] && (swap_reg != '1))
                        swap_next = swap_reg + 1'b1;
                    case (sel)
                        4'b0001: out_kind_next = K_VERTEX;
                        4'b0010: out_kind_next = K_SAME;
                        4'b0100: out_kind_next = K_SWAP;
                        4'b1000: out_kind_next = K_SWAP;
                        default: out_kind_next = K_TALLY;
                    endcase
                    out_vertex_next = vertex_next;
                    out_same_next   = same_next;
                    out_swap_next   = swap_next;
                    if ((remain == 4'd0) && !last_i)
                        i_next = i_reg + 1'b1;
                end
            end
            S_TALLY:
            begin
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_final_next  = 1'b1;
                    out_kind_next   = K_TALLY;
                    out_cell_next   = '0;
                    out_step_next   = timestep_reg;
                    out_vertex_next = vertex_reg;
                    out_same_next   = same_reg;
                    out_swap_next   = swap_reg;
                    if (step_end_reg)
                    begin
                        // swapping banks turns the current cells into the previous ones
                        bank_next         = !bank_reg;
                        prev_present_next = cur_present_reg;
                        cur_present_next  = '0;
                        if (timestep_reg != '1)
                            timestep_next = timestep_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                i_next = '0;
            end
        endcase
    end

    // read addresses follow the next index so data lines up with i_reg
    always_comb
    begin
        if (state_next == S_PREV)
            rd_a_addr = {!bank_reg, me_in};
        else
            rd_a_addr = {bank_reg, i_next};
        rd_b_addr = {!bank_reg, i_next};
    end

    pcc_cell_mem #(
        .IDX_W  (AW),
        .CELL_W (CW)
    ) u_cells (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (cell_in),
        .rd_a_addr (rd_a_addr),
        .rd_b_addr (rd_b_addr),
        .rd_a_data (rd_a_data),
        .rd_b_data (rd_b_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            i_reg            <= '0;
            pend_reg         <= '0;
            bank_reg         <= 1'b0;
            cur_present_reg  <= '0;
            prev_present_reg <= '0;
            timestep_reg     <= '0;
            vertex_reg       <= '0;
            same_reg         <= '0;
            swap_reg         <= '0;
            out_valid_reg    <= 1'b0;
            step_end_reg     <= 1'b0;
            edge_ok_reg      <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            i_reg            <= i_next;
            pend_reg         <= pend_next;
            bank_reg         <= bank_next;
            cur_present_reg  <= cur_present_next;
            prev_present_reg <= prev_present_next;
            timestep_reg     <= timestep_next;
            vertex_reg       <= vertex_next;
            same_reg         <= same_next;
            swap_reg         <= swap_next;
            out_valid_reg    <= out_valid_next;
            step_end_reg     <= step_end_next;
            edge_ok_reg      <= edge_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        me_reg         <= me_next;
        cell_reg       <= cell_next;
        prev_me_reg    <= prev_me_next;
        out_kind_reg   <= out_kind_next;
        out_cell_reg   <= out_cell_next;
        out_step_reg   <= out_step_next;
        out_vertex_reg <= out_vertex_next;
        out_same_reg   <= out_same_next;
        out_swap_reg   <= out_swap_next;
        out_final_reg  <= out_final_next;
    end

    assign report.valid        = out_valid_reg;
    assign report.kind         = out_kind_reg;
    assign report.at_x         = XY_W'(out_cell_reg[COORD_BITS-1:0]);
    assign report.at_y         = XY_W'(out_cell_reg[CW-1:COORD_BITS]);
    assign report.at_step      = out_step_reg;
    assign report.vertex_total = out_vertex_reg;
    assign report.same_total   = out_same_reg;
    assign report.swap_total   = out_swap_reg;
    assign report.final_res    = out_final_reg;

`ifndef SYNTH
    a_scan_below_agent: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> (i_reg < me_reg))
        else $error("comparator index reached the arriving agent");

    a_tally_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        report.valid |-> ((report.kind == K_TALLY) == report.final_res))
        else $error("final flag does not match tally kind");

    a_swap_pair: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg[P_SWAP_A] |-> pend_reg[P_SWAP_B])
        else $error("swap record pending without its second record");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (path.valid && path.ready) |=> !path.ready)
        else $error("request accepted but sequencer stayed idle");
`endif

endmodule

FILE: tb/path_conflict_counter_test.sv
// self-checking test of path_conflict_counter: directed and random agent paths
// a scoreboard class predicts conflict records and tallies, then checks them
// depends on pcc_pkg, pcc_if and the block's rtl
`timescale 1ns / 1ps

import pcc_pkg::*;

typedef struct packed {
    logic [AGENT_W-1:0] agent;
    logic [XY_W-1:0]    pos_x;
    logic [XY_W-1:0]    pos_y;
    logic               present;
    logic               step_end;
    logic               restart;
} path_req_t;

typedef struct packed {
    kind_t              kind;
    logic [XY_W-1:0]    at_x;
    logic [XY_W-1:0]    at_y;
    logic [STEP_W-1:0]  at_step;
    logic [TOT_W-1:0]   vertex_total;
    logic [TOT_W-1:0]   same_total;
    logic [TOT_W-1:0]   swap_total;
    logic               final_res;
} report_rec_t;

class conflict_scoreboard;
    logic [PCC_MAX_AGENTS-1:0][2*XY_W-1:0] cur_cell;
    logic [PCC_MAX_AGENTS-1:0][2*XY_W-1:0] prev_cell;
    logic [PCC_MAX_AGENTS-1:0]             cur_present;
    logic [PCC_MAX_AGENTS-1:0]             prev_present;
    logic [STEP_W-1:0]                     cur_step;
    logic [TOT_W-1:0]                      vertex_cnt;
    logic [TOT_W-1:0]                      same_cnt;
    logic [TOT_W-1:0]                      swap_cnt;
    report_rec_t                           awaited_reports[$];
    int                                    mismatch_cnt;

    function new();
        cur_cell     = '0;
        prev_cell    = '0;
        cur_present  = '0;
        prev_present = '0;
        cur_step     = '0;
        vertex_cnt   = '0;
        same_cnt     = '0;
        swap_cnt     = '0;
        mismatch_cnt = 0;
    endfunction

    function logic [TOT_W-1:0] sat_inc(logic [TOT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function void push_record(kind_t k, logic [2*XY_W-1:0] at_cell, logic last);
        report_rec_t e;
        e.kind         = k;
        e.at_x         = at_cell[XY_W-1:0];
        e.at_y         = at_cell[2*XY_W-1:XY_W];
        e.at_step      = cur_step;
        e.vertex_total = vertex_cnt;
        e.same_total   = same_cnt;
        e.swap_total   = swap_cnt;
        e.final_res    = last;
        awaited_reports.insert(awaited_reports.size(), e);
    endfunction

    // works out every record one accepted request causes
    function void predict_conflicts(path_req_t r);
        logic [2*XY_W-1:0] pos_cell;
        logic              edge_ok;
        if (r.restart)
        begin
            vertex_cnt   = '0;
            same_cnt     = '0;
            swap_cnt     = '0;
            cur_step     = '0;
            cur_present  = '0;
            prev_present = '0;
        end
        if (r.present)
        begin
            pos_cell = {r.pos_y, r.pos_x};
            for (int i = 0; i < r.agent; i++)
            begin
                if (!cur_present[i])
                    continue;
                edge_ok = (cur_step != 0) && prev_present[i] && prev_present[r.agent];
                if (cur_cell[i] == pos_cell)
                begin
                    vertex_cnt = sat_inc(vertex_cnt);
                    push_record(K_VERTEX, cur_cell[i], 1'b0);
                end
                if (edge_ok && prev_cell[i] == prev_cell[r.agent] && cur_cell[i] == pos_cell)
                begin
                    same_cnt = sat_inc(same_cnt);
                    push_record(K_SAME, cur_cell[i], 1'b0);
                end
                if (edge_ok && prev_cell[i] == pos_cell && prev_cell[r.agent] == cur_cell[i])
                begin
                    swap_cnt = sat_inc(swap_cnt);
                    push_record(K_SWAP, cur_cell[i], 1'b0);
                    push_record(K_SWAP, pos_cell, 1'b0);
                end
            end
            cur_cell[r.agent]    = pos_cell;
            cur_present[r.agent] = 1'b1;
        end
        else
            cur_present[r.agent] = 1'b0;
        push_record(K_TALLY, '0, 1'b1);
        if (r.step_end)
        begin
            prev_cell    = cur_cell;
            prev_present = cur_present;
            cur_present  = '0;
            if (cur_step != '1)
                cur_step = cur_step + 1'b1;
        end
    endfunction

    function void check_report(report_rec_t got);
        report_rec_t want;
        if (awaited_reports.size() == 0)
        begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
                $display("%0t: report with none awaited: kind %0d x %0d y %0d step %0d",
                         $realtime, got.kind, got.at_x, got.at_y, got.at_step);
            return;
        end
        want = awaited_reports.pop_front();
        if (got.kind !== want.kind || got.at_x !== want.at_x || got.at_y !== want.at_y ||
            got.at_step !== want.at_step || got.vertex_total !== want.vertex_total ||
            got.same_total !== want.same_total || got.swap_total !== want.swap_total ||
            got.final_res !== want.final_res)
        begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
            begin
                $display("%0t: report mismatch", $realtime);
                $display("    expected kind %0d x %0d y %0d step %0d tot %0d/%0d/%0d last %0b",
                         want.kind, want.at_x, want.at_y, want.at_step,
                         want.vertex_total, want.same_total, want.swap_total, want.final_res);
                $display("    got kind %0d x %0d y %0d step %0d tot %0d/%0d/%0d last %0b",
                         got.kind, got.at_x, got.at_y, got.at_step,
                         got.vertex_total, got.same_total, got.swap_total, got.final_res);
            end
        end
    endfunction
endclass

module path_conflict_counter_test;

    localparam int CYCLE_LIMIT  = 3000000;
    localparam int TAIL_CYCLES  = 64;
    localparam int RANDOM_ITEMS = 350;

    logic clk = 1'b0;
    logic rst_n;

    pcc_path_if   path_ch ();
    pcc_report_if report_ch ();

    path_conflict_counter dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .path   (path_ch),
        .report (report_ch)
    );

    conflict_scoreboard tally_board;
    bit idle_on;
    bit stall_on;
    int requests_sent;
    int cycle_count;

    always #2 clk = ~clk;

    function automatic path_req_t mk_req(int agent, int x, int y, bit present,
                                         bit step_end, bit restart);
        path_req_t r;
        r.agent    = AGENT_W'(agent);
        r.pos_x    = XY_W'(x);
        r.pos_y    = XY_W'(y);
        r.present  = present;
        r.step_end = step_end;
        r.restart  = restart;
        return r;
    endfunction

    task automatic send_req(path_req_t r);
        while (idle_on && $urandom_range(99) < 29)
        begin
            path_ch.valid <= 1'b0;
            @(posedge clk);
        end
        path_ch.valid    <= 1'b1;
        path_ch.agent    <= r.agent;
        path_ch.pos_x    <= r.pos_x;
        path_ch.pos_y    <= r.pos_y;
        path_ch.present  <= r.present;
        path_ch.step_end <= r.step_end;
        path_ch.restart  <= r.restart;
        @(posedge clk);
        while (!path_ch.ready)
            @(posedge clk);
        tally_board.predict_conflicts(r);
        requests_sent++;
    endtask

    // hold the path channel until every awaited record has come out
    task automatic drain_reports();
        path_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (tally_board.awaited_reports.size() != 0);
    endtask

    // report side: random backpressure, check each accepted record
    initial
    begin
        report_rec_t seen;
        report_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && report_ch.valid === 1'b1 && report_ch.ready === 1'b1)
            begin
                seen.kind         = kind_t'(report_ch.kind);
                seen.at_x         = report_ch.at_x;
                seen.at_y         = report_ch.at_y;
                seen.at_step      = report_ch.at_step;
                seen.vertex_total = report_ch.vertex_total;
                seen.same_total   = report_ch.same_total;
                seen.swap_total   = report_ch.swap_total;
                seen.final_res    = report_ch.final_res;
                tally_board.check_report(seen);
            end
            report_ch.ready <= !stall_on || ($urandom_range(99) >= 29);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        path_req_t         r;
        logic [XY_W-1:0]   base_x;
        logic [XY_W-1:0]   base_y;
        int                span_x;
        int                span_y;
        int                n_steps;
        int                last_agent;
        int                random_start;
        bit                take[PCC_MAX_AGENTS];
        bit                restart_next;

        tally_board      = new();
        idle_on          = 1'b1;
        stall_on         = 1'b1;
        requests_sent    = 0;
        rst_n            = 1'b0;
        path_ch.valid    = 1'b0;
        path_ch.agent    = '0;
        path_ch.pos_x    = '0;
        path_ch.pos_y    = '0;
        path_ch.present  = 1'b0;
        path_ch.step_end = 1'b0;
        path_ch.restart  = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // step 0: vertex, absent agent, coordinate extremes
        send_req(mk_req(0, 5, 5, 1, 0, 1));
        send_req(mk_req(1, 5, 5, 1, 0, 0));
        send_req(mk_req(2, 0, 0, 0, 0, 0));
        send_req(mk_req(3, 1023, 1023, 1, 0, 0));
        send_req(mk_req(7, 0, 0, 1, 1, 0));
        // step 1: vertex with same-direction move, swap between agents 3 and 7
        send_req(mk_req(0, 6, 5, 1, 0, 0));
        send_req(mk_req(1, 6, 5, 1, 0, 0));
        send_req(mk_req(3, 0, 0, 1, 0, 0));
        send_req(mk_req(7, 1023, 1023, 1, 1, 0));
        // step 2: repeated agent, out-of-order agent, absent agent ends the step
        send_req(mk_req(2, 3, 3, 1, 0, 0));
        send_req(mk_req(2, 682, 341, 1, 0, 0));
        send_req(mk_req(5, 9, 9, 1, 0, 0));
        send_req(mk_req(4, 9, 9, 1, 0, 0));
        send_req(mk_req(6, 9, 9, 1, 0, 0));
        send_req(mk_req(5, 0, 0, 0, 1, 0));
        // step 3: both agents stay put, all three kinds at once
        send_req(mk_req(4, 9, 9, 1, 0, 0));
        send_req(mk_req(6, 9, 9, 1, 0, 0));
        send_req(mk_req(2, 341, 682, 1, 1, 0));
        // restart in the middle of a run, then an empty step
        send_req(mk_req(3, 1, 1, 1, 1, 1));
        send_req(mk_req(0, 0, 0, 0, 1, 0));
        // every agent on one cell for two steps gives the largest burst
        for (int a = 0; a < PCC_MAX_AGENTS; a++)
            send_req(mk_req(a, 512, 512, 1, a == PCC_MAX_AGENTS - 1, 0));
        for (int a = 0; a < PCC_MAX_AGENTS; a++)
            send_req(mk_req(a, 512, 512, 1, a == PCC_MAX_AGENTS - 1, 0));
        drain_reports();

        random_start = requests_sent;
        restart_next = 1'b1;
        while (requests_sent - random_start < RANDOM_ITEMS)
        begin
            // quiet stretch with neither side idling
            idle_on  = !((requests_sent - random_start) >= 120 &&
                         (requests_sent - random_start) < 200);
            stall_on = idle_on;
            if ($urandom_range(9) == 0)
            begin
                // noise: unordered agents, random presence and step ends
                repeat ($urandom_range(1, 3))
                begin
                    r.agent    = AGENT_W'($urandom_range(PCC_MAX_AGENTS - 1));
                    r.pos_x    = XY_W'($urandom_range(1023));
                    r.pos_y    = XY_W'($urandom_range(1023));
                    r.present  = 1'($urandom_range(1));
                    r.step_end = 1'($urandom_range(1));
                    r.restart  = $urandom_range(7) == 0;
                    send_req(r);
                end
            end
            else
            begin
                // a run of well-formed steps crowded onto a tiny patch of grid
                base_x  = XY_W'($urandom_range(1020));
                base_y  = XY_W'($urandom_range(1020));
                span_x  = $urandom_range(1, 3);
                span_y  = $urandom_range(1, 2);
                n_steps = $urandom_range(2, 6);
                repeat (n_steps)
                begin
                    last_agent = -1;
                    for (int a = 0; a < PCC_MAX_AGENTS; a++)
                    begin
                        take[a] = $urandom_range(99) < 80;
                        if (take[a])
                            last_agent = a;
                    end
                    if (last_agent < 0)
                    begin
                        take[0]    = 1'b1;
                        last_agent = 0;
                    end
                    for (int a = 0; a <= last_agent; a++)
                    begin
                        if (!take[a])
                            continue;
                        r.agent      = AGENT_W'(a);
                        r.pos_x      = XY_W'(base_x + $urandom_range(span_x - 1));
                        r.pos_y      = XY_W'(base_y + $urandom_range(span_y - 1));
                        r.present    = $urandom_range(9) != 0;
                        r.step_end   = (a == last_agent);
                        r.restart    = restart_next;
                        restart_next = 1'b0;
                        send_req(r);
                    end
                end
                restart_next = $urandom_range(3) == 0;
            end
            if (requests_sent - random_start >= 250 && requests_sent - random_start < 265)
                drain_reports();
        end
        idle_on  = 1'b1;
        stall_on = 1'b1;
        drain_reports();

        // restart, then a vertex and same-direction move of two agents with neither side idling
        idle_on  = 1'b0;
        stall_on = 1'b0;
        send_req(mk_req(0, 0, 0, 0, 1, 1));
        send_req(mk_req(0, 1023, 0, 1, 0, 0));
        send_req(mk_req(1, 1023, 0, 1, 1, 0));
        send_req(mk_req(0, 0, 1023, 1, 0, 0));
        send_req(mk_req(1, 0, 1023, 1, 1, 0));
        idle_on  = 1'b1;
        stall_on = 1'b1;
        send_req(mk_req(1, 0, 1023, 1, 1, 1));

        drain_reports();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (tally_board.mismatch_cnt == 0 && tally_board.awaited_reports.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
